@@ rtl/bmbc_pkg.sv @@
// Shared constants and control types for the border median background colour block.
// No dependencies; every other file except bmbc_ram takes this package by wildcard import.
`timescale 1ns / 1ps

package bmbc_pkg;

   // configuration register layout
   localparam int CFG_W  = 13;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

   // frame size limits (defaults for the top level parameters)
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // pixels and histograms
   localparam int PIX_W     = 8;
   localparam int NUM_CH    = 3;
   localparam int CH_BLUE   = 0;
   localparam int CH_GREEN  = 1;
   localparam int CH_RED    = 2;
   localparam int HIST_BINS = 256;
   localparam int HIST_AW   = 8;
   localparam int CNT_W     = 24;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // band = max(2, shorter side / 25); the division is a multiply by
   // ceil(2^20/25), exact for any side below 43690
   localparam int BAND_MIN   = 2;
   localparam int BAND_RECIP = 41944;
   localparam int RECIP_W    = 16;
   localparam int BAND_SHIFT = 20;

   // controller to datapath
   typedef struct packed {
      logic clear;      // write zero to the bin under the sweep index
      logic accept;     // capture the pixel, histogram read in flight
      logic update;     // read-modify-write the bins, advance position
      logic walk_init;  // start the median walk
      logic walk;       // read one bin, zero it, advance the index
      logic load_out;   // move the medians to the output register
   } bmbc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_bin;   // sweep index is on the final bin
      logic frame_end;  // current pixel closes the frame
      logic out_free;   // output register can take a result
   } bmbc_sts_type;

endpackage

@@ rtl/bmbc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Read-first: a read and a write to one address in a cycle return the old word.
`timescale 1ns / 1ps

module bmbc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bmbc_csr.sv @@
// APB-style configuration registers: frame width and frame height.
// Uses bmbc_pkg for the register map and reset values.
`timescale 1ns / 1ps

module bmbc_csr
   import bmbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output logic [CFG_W-1:0]  frame_width,
   output logic [CFG_W-1:0]  frame_height
);

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic [0:0]       reg_sel;
   logic             wr_en;

   // word select, byte offset ignored
   assign reg_sel = paddr[CSR_AW-1];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // write decode
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FRAME_WIDTH:  frame_width_in  = pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         REG_FRAME_WIDTH:  prdata = CSR_DW'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DW'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   assign frame_width  = frame_width_ff;
   assign frame_height = frame_height_ff;

endmodule

@@ rtl/bmbc_ctrl.sv @@
// Controller state machine: clearing pass, per-pixel update, median walk, result hand-off.
// Uses bmbc_pkg for the command and status structs.
`timescale 1ns / 1ps

module bmbc_ctrl
   import bmbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bmbc_sts_type sts,
   output bmbc_cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_UPD   = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.last_bin) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            if (sts.frame_end) begin
               cmd.walk_init = 1'b1;
               state_in      = ST_WALK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.last_bin) begin
               state_in = ST_DRAIN;
            end
         end
         // last bin's data arrives here
         ST_DRAIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/bmbc_dp.sv @@
// Datapath: raster position, band test, three histogram RAMs, median walk, output register.
// Uses bmbc_pkg and bmbc_ram; driven by bmbc_ctrl through the command struct.
`timescale 1ns / 1ps

module bmbc_dp
   import bmbc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  bmbc_cmd_type     cmd,
   output bmbc_sts_type     sts,
   input  logic [CFG_W-1:0] frame_width,
   input  logic [CFG_W-1:0] frame_height,
   input  logic [PIX_W-1:0] req_pixel_blue,
   input  logic [PIX_W-1:0] req_pixel_green,
   input  logic [PIX_W-1:0] req_pixel_red,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_median_blue,
   output logic [PIX_W-1:0] rsp_median_green,
   output logic [PIX_W-1:0] rsp_median_red
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int SW    = ((XW > YW) ? XW : YW) + 2;
   localparam int PW    = SW + RECIP_W;
   localparam int CUM_W = CNT_W + 1;

   // zero reads as one, oversize saturates
   function automatic logic [SW-1:0] clamp_size(input logic [CFG_W-1:0] v, input int maxv);
      logic [SW-1:0] r;
      if (v == '0) begin
         r = SW'(1);
      end else if (32'(v) > 32'(maxv)) begin
         r = SW'(maxv);
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

   logic [SW-1:0]      w_c, h_c, shorter, band_q, band_in, band_ff;
   logic [PW-1:0]      band_prod;
   logic [XW-1:0]      x_ff, x_in;
   logic [YW-1:0]      y_ff, y_in;
   logic [SW-1:0]      x_e, y_e, x_next, y_next;
   logic               border, row_end, frame_end;
   logic [CNT_W-1:0]   count_ff, count_in, rank;
   logic [HIST_AW-1:0] idx_ff;
   logic [HIST_AW-1:0] bin_d_ff;
   logic               rd_pend_ff;
   logic               rsp_valid_ff;

   logic [PIX_W-1:0]   pix_in   [NUM_CH];
   logic [PIX_W-1:0]   pix_ff   [NUM_CH];
   logic [CNT_W-1:0]   rd_data  [NUM_CH];
   logic [CUM_W-1:0]   cum_ff   [NUM_CH];
   logic [CUM_W-1:0]   cum_sum  [NUM_CH];
   logic               found_ff [NUM_CH];
   logic [PIX_W-1:0]   med_ff   [NUM_CH];
   logic [PIX_W-1:0]   out_ff   [NUM_CH];

   assign pix_in[CH_BLUE]  = req_pixel_blue;
   assign pix_in[CH_GREEN] = req_pixel_green;
   assign pix_in[CH_RED]   = req_pixel_red;

   // frame size and band width
   assign w_c       = clamp_size(frame_width, MAX_WIDTH);
   assign h_c       = clamp_size(frame_height, MAX_HEIGHT);
   assign shorter   = (w_c < h_c) ? w_c : h_c;
   assign band_prod = PW'(shorter) * PW'(BAND_RECIP);
   assign band_q    = SW'(band_prod >> BAND_SHIFT);
   assign band_in   = (band_q < SW'(BAND_MIN)) ? SW'(BAND_MIN) : band_q;

   always_ff @(posedge clock) begin
      band_ff <= band_in;
   end

   // border test and raster advance
   assign x_e       = SW'(x_ff);
   assign y_e       = SW'(y_ff);
   assign border    = (y_e < band_ff) || (y_e + band_ff >= h_c) ||
                      (x_e < band_ff) || (x_e + band_ff >= w_c);
   assign x_next    = x_e + SW'(1);
   assign y_next    = y_e + SW'(1);
   assign row_end   = (x_next >= w_c);
   assign frame_end = row_end && (y_next >= h_c);

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      count_in = count_ff;
      if (cmd.update) begin
         if (border) begin
            count_in = sat_inc(count_ff);
         end
         if (row_end) begin
            x_in = '0;
            y_in = frame_end ? '0 : YW'(y_next);
         end else begin
            x_in = XW'(x_next);
         end
      end else if (cmd.load_out) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff       <= '0;
         y_ff       <= '0;
         count_ff   <= '0;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         count_ff   <= count_in;
         rd_pend_ff <= cmd.walk;
         if (cmd.clear || cmd.walk) begin
            idx_ff <= idx_ff + HIST_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_d_ff <= idx_ff;
   end

   assign rank = count_ff >> 1;

   // per channel histogram and walk
   for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      logic               ram_we;
      logic [HIST_AW-1:0] ram_waddr;
      logic [HIST_AW-1:0] ram_raddr;
      logic [CNT_W-1:0]   ram_wdata;

      assign ram_we    = (cmd.update && border) || cmd.walk || cmd.clear;
      assign ram_waddr = cmd.update ? pix_ff[c] : idx_ff;
      assign ram_wdata = cmd.update ? sat_inc(rd_data[c]) : '0;
      assign ram_raddr = cmd.walk ? idx_ff : pix_in[c];

      bmbc_ram #(
         .WIDTH (CNT_W),
         .DEPTH (HIST_BINS)
      ) u_hist (
         .clock (clock),
         .we    (ram_we),
         .waddr (ram_waddr),
         .wdata (ram_wdata),
         .raddr (ram_raddr),
         .rdata (rd_data[c])
      );

      always_ff @(posedge clock) begin
         if (cmd.accept) begin
            pix_ff[c] <= pix_in[c];
         end
      end

      assign cum_sum[c] = cum_ff[c] + CUM_W'(rd_data[c]);

      // first bin whose running total passes the rank holds the median
      always_ff @(posedge clock) begin
         if (reset) begin
            found_ff[c] <= 1'b0;
         end else if (cmd.walk_init) begin
            found_ff[c] <= 1'b0;
         end else if (rd_pend_ff && !found_ff[c] && (cum_sum[c] > CUM_W'(rank))) begin
            found_ff[c] <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.walk_init) begin
            cum_ff[c] <= '0;
            med_ff[c] <= PIX_W'(HIST_BINS - 1);
         end else if (rd_pend_ff && !found_ff[c]) begin
            if (cum_sum[c] > CUM_W'(rank)) begin
               med_ff[c] <= bin_d_ff;
            end else begin
               cum_ff[c] <= cum_sum[c];
            end
         end
      end

      // output payload, empty border set gives zero
      always_ff @(posedge clock) begin
         if (cmd.load_out) begin
            out_ff[c] <= (count_ff == '0) ? '0 : med_ff[c];
         end
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_blue  = out_ff[CH_BLUE];
   assign rsp_median_green = out_ff[CH_GREEN];
   assign rsp_median_red   = out_ff[CH_RED];

   assign sts.last_bin  = (idx_ff == '1);
   assign sts.frame_end = frame_end;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

@@ rtl/border_median_background_colour.sv @@
// Border median background colour: top level.
// Uses bmbc_pkg, bmbc_csr, bmbc_ctrl, bmbc_dp (with bmbc_ram).
//
// Usage:
//   req_*  : BGR pixels of one frame in raster order, valid/stall handshake.
//   rsp_*  : one item per frame, the median blue, green and red over the
//            pixels in the border band (band = max(2, min(w,h)/25)).
//   csr_*  : frame_width at byte 0, frame_height at byte 4; write while idle.
// Pixel input: no new pixel is taken while the last one's bins go through a
//   read-modify-write on the registered read port of each histogram RAM.
// Result path: after the frame's last pixel is accepted come its bin update,
//   a 256-bin walk through the RAMs that also zeroes each bin, a drain state,
//   and a load into the output register once that register is free.
// Reset: a clearing pass over all 256 bins zeroes them; req_stall stays high
//   through it. Sizes return to 640 x 480.
// Receiver stall: the result waits in the output register and the next frame
//   streams in meanwhile; a second result waits behind it until it is taken.
`timescale 1ns / 1ps

module border_median_background_colour
   import bmbc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PIX_W-1:0]  req_pixel_blue,
   input  logic [PIX_W-1:0]  req_pixel_green,
   input  logic [PIX_W-1:0]  req_pixel_red,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PIX_W-1:0]  rsp_median_blue,
   output logic [PIX_W-1:0]  rsp_median_green,
   output logic [PIX_W-1:0]  rsp_median_red,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   bmbc_cmd_type     cmd;
   bmbc_sts_type     sts;
   logic [CFG_W-1:0] frame_width;
   logic [CFG_W-1:0] frame_height;

   bmbc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .frame_width  (frame_width),
      .frame_height (frame_height)
   );

   bmbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmbc_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .frame_width      (frame_width),
      .frame_height     (frame_height),
      .req_pixel_blue   (req_pixel_blue),
      .req_pixel_green  (req_pixel_green),
      .req_pixel_red    (req_pixel_red),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_median_blue  (rsp_median_blue),
      .rsp_median_green (rsp_median_green),
      .rsp_median_red   (rsp_median_red)
   );

endmodule

@@ rtl/bmbc_chk.sv @@
// Port-level checker for border_median_background_colour, attached by bind.
// Uses bmbc_pkg for field widths.
`timescale 1ns / 1ps

module bmbc_chk
   import bmbc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [PIX_W-1:0] rsp_median_blue,
   input logic [PIX_W-1:0] rsp_median_green,
   input logic [PIX_W-1:0] rsp_median_red
);

   // clearing pass blocks input and no result is shown after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (req_stall && !rsp_valid))
      else $error("input open or result shown right after reset");

   // input is held while each accepted pixel's bin update runs
   a_pixel_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("pixel accepted in back-to-back cycles");

   // a result is only loaded while the input side is held
   a_load_held: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while input was open");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         $stable({rsp_median_blue, rsp_median_green, rsp_median_red}))
      else $error("result payload changed while stalled");

endmodule

bind border_median_background_colour bmbc_chk u_bmbc_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_median_blue  (rsp_median_blue),
   .rsp_median_green (rsp_median_green),
   .rsp_median_red   (rsp_median_red)
);
